FILE: rtl/bcz_pkg.sv
`default_nettype none
package bcz_pkg;

	localparam int CoordW = 24;
	localparam int TW     = 17;
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [TW-1:0] T_ONE = 17'h10000;

	localparam logic KIND_EVAL  = 1'b0;
	localparam logic KIND_SPLIT = 1'b1;

	// output run positions in split mode
	localparam logic [2:0] IDX_LEFT_START = 3'd0;
	localparam logic [2:0] IDX_LEFT_CTRL1 = 3'd1;
	localparam logic [2:0] IDX_LEFT_CTRL2 = 3'd2;
	localparam logic [2:0] IDX_SPLIT      = 3'd3;
	localparam logic [2:0] IDX_RIGHT_CTRL1 = 3'd4;
	localparam logic [2:0] IDX_RIGHT_CTRL2 = 3'd5;
	localparam logic [2:0] IDX_RIGHT_END  = 3'd6;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		logic            kind;
		coord_t          start_x;
		coord_t          start_y;
		coord_t          ctrl_one_x;
		coord_t          ctrl_one_y;
		coord_t          ctrl_two_x;
		coord_t          ctrl_two_y;
		coord_t          end_x;
		coord_t          end_y;
		logic [TW-1:0]   t_param;
	} in_item_t;

	typedef struct packed {
		coord_t     point_x;
		coord_t     point_y;
		logic [2:0] point_index;
		logic       last;
	} out_item_t;

	// everything the back end needs to emit either run
	typedef struct packed {
		logic   kind;
		point_t p0;
		point_t a10;
		point_t a12;
		point_t a20;
		point_t a21;
		point_t mid;
		point_t p3;
	} entry_t;

	// a + floor(t*(b-a) / 2^16), t in [0, 1.0]
	function automatic coord_t lerp(coord_t a, coord_t b, logic [TW-1:0] t);
		logic signed [CoordW:0]      d;
		logic signed [CoordW+TW+1:0] p;
		logic signed [CoordW+TW+1:0] s;
		d = {b[CoordW-1], b} - {a[CoordW-1], a};
		p = $signed({1'b0, t}) * d;
		s = (CoordW+TW+2)'(a) + (p >>> 16);
		return s[CoordW-1:0];
	endfunction

	function automatic point_t lerp_pt(point_t a, point_t b, logic [TW-1:0] t);
		point_t r;
		r.x = lerp(a.x, b.x, t);
		r.y = lerp(a.y, b.y, t);
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cubic_bezier_eval_split_unit.sv
// A result passes through the front stages, the queue and the output register.
// Throughput, while out_ready is high: one evaluate item per cycle; a split
// item emits seven points, one a cycle, set by the single output register.
// The 4-entry queue lets the front keep taking items while splits drain.
// Reset (arst_n low, asynchronous) empties the pipe, the queue and the output.
`default_nettype none
module cubic_bezier_eval_split_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bcz_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bcz_pkg::out_item_t      out_data
);
	import bcz_pkg::*;

	// front to queue
	logic   q_full;
	logic   q_push;
	entry_t q_entry;
	// queue to back
	logic   q_not_empty;
	logic   q_pop;
	entry_t q_head;

	// Front: saturate t and run the three de Casteljau levels, the last combinationally.
	// Hold every stage while the queue is full and the last stage is loaded.
	bcz_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	// Queue: decouple curve computation from the output run.
	bcz_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (q_entry),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (q_head)
	);

	// Back: walk the head entry, one point per output transfer; drop the
	// entry once its final point has been loaded.
	bcz_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

FILE: rtl/bcz_front.sv
`default_nettype none
module bcz_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire bcz_pkg::in_item_t in_data,
	input  wire logic             q_full,
	output logic                  q_push,
	output bcz_pkg::entry_t       q_entry
);
	import bcz_pkg::*;

	logic          en;
	logic          v_s1, v_s2, v_s3;
	logic          kind_s1, kind_s2, kind_s3;
	logic [TW-1:0] t_s1, t_s2, t_s3;
	point_t        p_s1 [4];
	point_t        p0_s2, p3_s2, p0_s3, p3_s3;
	point_t        a1_s2 [3];
	point_t        a10_s3, a12_s3;
	point_t        a2_s3 [2];
	logic [TW-1:0] t_sat;

	// whole pipe holds while the last stage cannot hand over
	assign en       = !(v_s3 && q_full);
	assign in_ready = en;
	assign q_push   = v_s3 && !q_full;
	assign t_sat    = (in_data.t_param > T_ONE) ? T_ONE : in_data.t_param;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1    <= in_data.kind;
			t_s1       <= t_sat;
			p_s1[0]    <= '{x: in_data.start_x,    y: in_data.start_y};
			p_s1[1]    <= '{x: in_data.ctrl_one_x, y: in_data.ctrl_one_y};
			p_s1[2]    <= '{x: in_data.ctrl_two_x, y: in_data.ctrl_two_y};
			p_s1[3]    <= '{x: in_data.end_x,      y: in_data.end_y};
			// first level
			kind_s2    <= kind_s1;
			t_s2       <= t_s1;
			p0_s2      <= p_s1[0];
			p3_s2      <= p_s1[3];
			for (int i = 0; i < 3; i++) begin
				a1_s2[i] <= lerp_pt(p_s1[i], p_s1[i+1], t_s1);
			end
			// second level
			kind_s3    <= kind_s2;
			t_s3       <= t_s2;
			p0_s3      <= p0_s2;
			p3_s3      <= p3_s2;
			a10_s3     <= a1_s2[0];
			a12_s3     <= a1_s2[2];
			for (int i = 0; i < 2; i++) begin
				a2_s3[i] <= lerp_pt(a1_s2[i], a1_s2[i+1], t_s2);
			end
		end
	end

	// third level feeds the queue directly
	always_comb begin
		q_entry.kind = kind_s3;
		q_entry.p0   = p0_s3;
		q_entry.a10  = a10_s3;
		q_entry.a12  = a12_s3;
		q_entry.a20  = a2_s3[0];
		q_entry.a21  = a2_s3[1];
		q_entry.mid  = lerp_pt(a2_s3[0], a2_s3[1], t_s3);
		q_entry.p3   = p3_s3;
	end

endmodule
`default_nettype wire

FILE: rtl/bcz_fifo.sv
`default_nettype none
module bcz_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bcz_pkg::entry_t wr_entry,
	output logic                 full,
	output logic                 not_empty,
	input  wire logic            pop,
	output bcz_pkg::entry_t      head
);
	import bcz_pkg::*;

	entry_t         mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAw:0]   count_q;

	assign full      = (count_q == (QAw+1)'(QDepth));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule
`default_nettype wire

FILE: rtl/bcz_back.sv
`default_nettype none
module bcz_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire bcz_pkg::entry_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bcz_pkg::out_item_t   out_data
);
	import bcz_pkg::*;

	logic       out_valid_q;
	out_item_t  out_q;
	logic [2:0] idx_q;
	logic       load;
	logic       run_end;
	point_t     pt;

	assign load      = !out_valid_q || out_ready;
	assign run_end   = (head.kind == KIND_EVAL) || (idx_q == IDX_RIGHT_END);
	assign pop       = load && head_valid && run_end;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		unique case (idx_q)
			IDX_LEFT_START:  pt = head.p0;
			IDX_LEFT_CTRL1:  pt = head.a10;
			IDX_LEFT_CTRL2:  pt = head.a20;
			IDX_SPLIT:       pt = head.mid;
			IDX_RIGHT_CTRL1: pt = head.a21;
			IDX_RIGHT_CTRL2: pt = head.a12;
			IDX_RIGHT_END:   pt = head.p3;
			default:         pt = head.p3;
		endcase
		if (head.kind == KIND_EVAL) pt = head.mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= IDX_LEFT_START;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= run_end ? IDX_LEFT_START : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q.point_x     <= pt.x;
			out_q.point_y     <= pt.y;
			out_q.point_index <= idx_q;
			out_q.last        <= run_end;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bcz_checker.sv
`default_nettype none
module bcz_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire bcz_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire bcz_pkg::out_item_t out_data
);
	import bcz_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.point_index == IDX_RIGHT_END) |-> out_data.last)
		else $error("right end point not marked last");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=>
			!out_valid || (out_data.point_index == $past(out_data.point_index) + 3'd1))
		else $error("split run out of order");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=>
			!out_valid || (out_data.point_index == IDX_LEFT_START))
		else $error("new run does not start at index zero");

endmodule

bind cubic_bezier_eval_split_unit bcz_checker u_bcz_checker (.*);
`default_nettype wire

FILE: dv/bezier_point_checker.sv
`default_nettype none
module bezier_point_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire bcz_pkg::in_item_t  in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire bcz_pkg::out_item_t out_data,
	output int                      mismatches,
	output int                      points_due
);
	import bcz_pkg::*;

	out_item_t due_points[$];
	int        err_total = 0;

	// a + floor(t*(b-a) / 2^16); the product fits easily in 64 bits
	function automatic longint blend(longint a, longint b, longint t);
		return a + ((t * (b - a)) >>> 16);
	endfunction

	function automatic out_item_t make_point(longint x, longint y, logic [2:0] idx,
			logic fin);
		out_item_t p;
		p.point_x     = coord_t'(x);
		p.point_y     = coord_t'(y);
		p.point_index = idx;
		p.last        = fin;
		return p;
	endfunction

	// queue the points one accepted curve must produce
	function automatic void split_curve(in_item_t c);
		longint px[4];
		longint py[4];
		longint l1x[3];
		longint l1y[3];
		longint l2x[2];
		longint l2y[2];
		longint mx;
		longint my;
		longint t;
		px[0] = c.start_x;    py[0] = c.start_y;
		px[1] = c.ctrl_one_x; py[1] = c.ctrl_one_y;
		px[2] = c.ctrl_two_x; py[2] = c.ctrl_two_y;
		px[3] = c.end_x;      py[3] = c.end_y;
		t = c.t_param;
		if (t > longint'(T_ONE))
			t = T_ONE;
		for (int i = 0; i < 3; i++) begin
			l1x[i] = blend(px[i], px[i + 1], t);
			l1y[i] = blend(py[i], py[i + 1], t);
		end
		for (int i = 0; i < 2; i++) begin
			l2x[i] = blend(l1x[i], l1x[i + 1], t);
			l2y[i] = blend(l1y[i], l1y[i + 1], t);
		end
		mx = blend(l2x[0], l2x[1], t);
		my = blend(l2y[0], l2y[1], t);
		if (c.kind == KIND_EVAL) begin
			due_points.push_back(make_point(mx, my, IDX_LEFT_START, 1'b1));
		end else begin
			due_points.push_back(make_point(px[0], py[0], IDX_LEFT_START, 1'b0));
			due_points.push_back(make_point(l1x[0], l1y[0], IDX_LEFT_CTRL1, 1'b0));
			due_points.push_back(make_point(l2x[0], l2y[0], IDX_LEFT_CTRL2, 1'b0));
			due_points.push_back(make_point(mx, my, IDX_SPLIT, 1'b0));
			due_points.push_back(make_point(l2x[1], l2y[1], IDX_RIGHT_CTRL1, 1'b0));
			due_points.push_back(make_point(l1x[2], l1y[2], IDX_RIGHT_CTRL2, 1'b0));
			due_points.push_back(make_point(px[3], py[3], IDX_RIGHT_END, 1'b1));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			due_points.delete();
			points_due <= 0;
			mismatches <= err_total;
		end else begin
			if (in_valid && in_ready)
				split_curve(in_data);
			if (out_valid && out_ready) begin
				if (due_points.size() == 0) begin
					err_total++;
					if (err_total <= 10)
						$display("unexpected point: x=%0d y=%0d idx=%0d last=%0b",
							out_data.point_x, out_data.point_y,
							out_data.point_index, out_data.last);
				end else begin
					want = due_points.pop_front();
					if (out_data.point_x !== want.point_x ||
							out_data.point_y !== want.point_y ||
							out_data.point_index !== want.point_index ||
							out_data.last !== want.last) begin
						err_total++;
						if (err_total <= 10)
							$display({"point mismatch: want x=%0d y=%0d idx=%0d ",
								"last=%0b, got x=%0d y=%0d idx=%0d last=%0b"},
								want.point_x, want.point_y, want.point_index,
								want.last, out_data.point_x, out_data.point_y,
								out_data.point_index, out_data.last);
					end
				end
			end
			points_due <= due_points.size();
			mismatches <= err_total;
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb_cubic_bezier_eval_split_unit.sv
`default_nettype none
module tb_cubic_bezier_eval_split_unit;
	import bcz_pkg::*;

	// Quiet cycles tolerated before the run is called hung. The slowest legal
	// gap between two transfers is the longest drawn sender gap or sink stall
	// plus the trip through the pipe, so this leaves a wide margin.
	localparam int HangLimit = 2000;
	localparam int RandomCurves = 156;

	localparam coord_t CoordMax = coord_t'(24'h7FFFFF);
	localparam coord_t CoordMin = coord_t'(24'h800000);

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int mismatches;
	int points_due;
	int quiet_cycles = 0;

	// idle modes: when set, the side never waits between transfers
	bit src_eager  = 1'b0;
	bit sink_eager = 1'b0;

	cubic_bezier_eval_split_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	bezier_point_checker i_point_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mismatches(mismatches),
		.points_due(points_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Coordinates lean towards the extremes and small values now and then, so
	// sign handling and the floor of negative products both get exercised.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0:       return CoordMax;
			1:       return CoordMin;
			2:       return coord_t'($signed($urandom_range(0, 2047)) - 1024);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Mostly t within [0, 1.0]; some exact ends and some values above 1.0
	// that the block must clamp.
	function automatic logic [TW-1:0] pick_t();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return T_ONE;
			2:       return TW'($urandom_range(65537, 131071));
			3:       return TW'($urandom_range(0, 15));
			default: return TW'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic in_item_t random_curve(logic kind);
		in_item_t c;
		c.kind       = kind;
		c.start_x    = pick_coord();
		c.start_y    = pick_coord();
		c.ctrl_one_x = pick_coord();
		c.ctrl_one_y = pick_coord();
		c.ctrl_two_x = pick_coord();
		c.ctrl_two_y = pick_coord();
		c.end_x      = pick_coord();
		c.end_y      = pick_coord();
		c.t_param    = pick_t();
		return c;
	endfunction

	// every point at one value
	function automatic in_item_t flat_curve(logic kind, coord_t v, logic [TW-1:0] t);
		in_item_t c;
		c.kind       = kind;
		c.start_x    = v;
		c.start_y    = v;
		c.ctrl_one_x = v;
		c.ctrl_one_y = v;
		c.ctrl_two_x = v;
		c.ctrl_two_y = v;
		c.end_x      = v;
		c.end_y      = v;
		c.t_param    = t;
		return c;
	endfunction

	// points swing between the two extremes, the widest differences possible
	function automatic in_item_t zigzag_curve(logic kind, bit flip, logic [TW-1:0] t);
		in_item_t c;
		coord_t   hi;
		coord_t   lo;
		hi = flip ? CoordMin : CoordMax;
		lo = flip ? CoordMax : CoordMin;
		c.kind       = kind;
		c.start_x    = lo;
		c.start_y    = hi;
		c.ctrl_one_x = hi;
		c.ctrl_one_y = lo;
		c.ctrl_two_x = lo;
		c.ctrl_two_y = hi;
		c.end_x      = hi;
		c.end_y      = lo;
		c.t_param    = t;
		return c;
	endfunction

	// Offer one curve: wait out the drawn gap, then hold valid and the payload
	// until the transfer. Valid stays high straight into the next curve when
	// no gap is drawn.
	task automatic send_curve(in_item_t c);
		int gap;
		gap = src_eager ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// hold the sender until every queued point has drained
	task automatic drain_points();
		in_valid <= 1'b0;
		do @(posedge clk); while (points_due != 0);
	endtask

	// stimulus and verdict
	initial begin
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flat and zigzag curves at the ends and middle of t, the clamp
		// above 1.0, and both kinds, then eight random curves
		send_curve(flat_curve(KIND_EVAL, '0, '0));
		send_curve(flat_curve(KIND_SPLIT, CoordMax, TW'(32768)));
		send_curve(flat_curve(KIND_SPLIT, CoordMin, T_ONE));
		send_curve(flat_curve(KIND_EVAL, CoordMin, TW'(1)));
		send_curve(zigzag_curve(KIND_EVAL, 1'b0, TW'(32768)));
		send_curve(zigzag_curve(KIND_SPLIT, 1'b0, TW'(1)));
		send_curve(zigzag_curve(KIND_SPLIT, 1'b1, TW'(65535)));
		send_curve(zigzag_curve(KIND_EVAL, 1'b1, T_ONE));
		send_curve(zigzag_curve(KIND_SPLIT, 1'b0, TW'(65537)));
		send_curve(zigzag_curve(KIND_EVAL, 1'b1, TW'(131071)));
		send_curve(zigzag_curve(KIND_SPLIT, 1'b1, '0));
		send_curve(flat_curve(KIND_EVAL, CoordMax, TW'(131071)));
		for (int i = 0; i < 8; i++)
			send_curve(random_curve(logic'(i[0])));
		drain_points();

		// random: six phases that walk through the four idle-mode pairings,
		// then two phases with drawn modes; hold off once halfway through
		for (int ph = 0; ph < 6; ph++) begin
			src_eager  = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
			sink_eager = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
			for (int i = 0; i < RandomCurves / 6; i++)
				send_curve(random_curve(logic'($urandom_range(0, 1))));
			if (ph == 2)
				drain_points();
		end
		in_valid <= 1'b0;

		// wait for the last points, then allow stragglers to show up
		do @(posedge clk); while (points_due != 0);
		repeat (12) @(posedge clk);
		if (mismatches == 0 && points_due == 0)
			$display("tb_cubic_bezier_eval_split_unit passed");
		else
			$display("tb_cubic_bezier_eval_split_unit failed");
		$finish;
	end

	// Sink: draw a stall per point, then hold ready until the transfer. Ready
	// is only dropped when a stall is actually drawn.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = sink_eager ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// watchdog: count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HangLimit) begin
				$display("tb_cubic_bezier_eval_split_unit failed");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire

FILE: cubic_bezier_eval_split_unit.f
rtl/bcz_pkg.sv
rtl/bcz_front.sv
rtl/bcz_fifo.sv
rtl/bcz_back.sv
rtl/cubic_bezier_eval_split_unit.sv
rtl/bcz_checker.sv
dv/bezier_point_checker.sv
dv/tb_cubic_bezier_eval_split_unit.sv
